@@ hw/rtl/ewl_pkg.sv @@
// Shared types, constants and the microcode table of the wear-levelling block.
package ewl_pkg;

  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned STEP_W      = 5;

  localparam logic [7:0] ERASED   = 8'hFF;
  localparam logic [7:0] HDR_LEN  = 8'd4;
  localparam logic [7:0] MIN_SIZE = 8'd3;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_START = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HDR_BAD = 2'd1,
    ST_OFF_BAD = 2'd2
  } status_e;

  // store address source
  typedef enum logic [1:0] {
    AS_HDR  = 2'd0,
    AS_BLK  = 2'd1,
    AS_USER = 2'd2
  } addr_sel_e;

  typedef enum logic [2:0] {
    WD_ZERO     = 3'd0,
    WD_CNT_IN   = 3'd1,
    WD_SIZE_IN  = 3'd2,
    WD_INIT_CHK = 3'd3,
    WD_REP_INC  = 3'd4,
    WD_ID       = 3'd5,
    WD_NEW_CHK  = 3'd6,
    WD_DATA     = 3'd7
  } wdata_sel_e;

  // destination of the byte read in the previous step
  typedef enum logic [2:0] {
    LD_NONE  = 3'd0,
    LD_CNT   = 3'd1,
    LD_SZ    = 3'd2,
    LD_ID    = 3'd3,
    LD_CHK   = 3'd4,
    LD_REP   = 3'd5,
    LD_WEAR  = 3'd6,
    LD_RDATA = 3'd7
  } load_e;

  typedef enum logic [1:0] {
    EX_NONE    = 2'd0,
    EX_BLK     = 2'd1,
    EX_NEXT_ID = 2'd2,
    EX_CLR_ID  = 2'd3
  } exec_e;

  typedef enum logic [2:0] {
    JC_NONE     = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_OP_INIT  = 3'd2,
    JC_OP_START = 3'd3,
    JC_OP_WRITE = 3'd4,
    JC_HDR_BAD  = 3'd5,
    JC_OFF_BAD  = 3'd6,
    JC_REP_FULL = 3'd7
  } jcond_e;

  typedef struct packed {
    addr_sel_e         asel;
    logic [2:0]        hofs;
    logic              rd;
    logic              wr;
    wdata_sel_e        wsel;
    load_e             ld;
    exec_e             ex;
    jcond_e            jc;
    logic [STEP_W-1:0] jtgt;
    logic              done;
    status_e           st;
  } ucode_t;

  typedef struct packed {
    logic op_init;
    logic op_start;
    logic op_write;
    logic hdr_bad;
    logic off_bad;
    logic rep_full;
    logic out_free;
  } cond_t;

  localparam logic [STEP_W-1:0] L_WBYTE    = 5'd12;
  localparam logic [STEP_W-1:0] L_FAIL_OFF = 5'd13;
  localparam logic [STEP_W-1:0] L_FAIL_HDR = 5'd14;
  localparam logic [STEP_W-1:0] L_START    = 5'd15;
  localparam logic [STEP_W-1:0] L_WEAR     = 5'd19;
  localparam logic [STEP_W-1:0] L_ROTATE   = 5'd21;
  localparam logic [STEP_W-1:0] L_INIT     = 5'd26;

  // Reads issued in step n land in the store's output register for step n+1.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      5'd0: begin
        w.rd = 1'b1; w.asel = AS_HDR; w.hofs = 3'd0;
        w.jc = JC_OP_INIT; w.jtgt = L_INIT;
      end
      5'd1: begin w.rd = 1'b1; w.asel = AS_HDR; w.hofs = 3'd1; w.ld = LD_CNT; end
      5'd2: begin w.rd = 1'b1; w.asel = AS_HDR; w.hofs = 3'd2; w.ld = LD_SZ; end
      5'd3: begin w.rd = 1'b1; w.asel = AS_HDR; w.hofs = 3'd3; w.ld = LD_ID; end
      5'd4: begin w.ld = LD_CHK; end
      5'd5: begin w.ex = EX_BLK; w.jc = JC_HDR_BAD; w.jtgt = L_FAIL_HDR; end
      5'd6: begin w.jc = JC_OP_START; w.jtgt = L_START; end
      5'd7: begin w.rd = 1'b1; w.asel = AS_BLK; end
      5'd8: begin w.ld = LD_WEAR; w.jc = JC_OFF_BAD; w.jtgt = L_FAIL_OFF; end
      5'd9: begin w.jc = JC_OP_WRITE; w.jtgt = L_WBYTE; end
      5'd10: begin w.rd = 1'b1; w.asel = AS_USER; end
      5'd11: begin w.ld = LD_RDATA; w.done = 1'b1; w.st = ST_OK; end
      5'd12: begin
        w.wr = 1'b1; w.asel = AS_USER; w.wsel = WD_DATA;
        w.done = 1'b1; w.st = ST_OK;
      end
      5'd13: begin w.done = 1'b1; w.st = ST_OFF_BAD; end
      5'd14: begin w.done = 1'b1; w.st = ST_HDR_BAD; end
      5'd15: begin w.rd = 1'b1; w.asel = AS_BLK; end
      5'd16: begin w.ld = LD_REP; end
      5'd17: begin w.jc = JC_REP_FULL; w.jtgt = L_ROTATE; end
      5'd18: begin w.wr = 1'b1; w.asel = AS_BLK; w.wsel = WD_REP_INC; end
      5'd19: begin w.rd = 1'b1; w.asel = AS_BLK; end
      5'd20: begin w.ld = LD_WEAR; w.done = 1'b1; w.st = ST_OK; end
      5'd21: begin w.ex = EX_NEXT_ID; end
      5'd22: begin w.ex = EX_BLK; end
      5'd23: begin w.wr = 1'b1; w.asel = AS_BLK; w.wsel = WD_ZERO; end
      5'd24: begin w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd2; w.wsel = WD_ID; end
      5'd25: begin
        w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd3; w.wsel = WD_NEW_CHK;
        w.jc = JC_ALWAYS; w.jtgt = L_WEAR;
      end
      5'd26: begin
        w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd0; w.wsel = WD_CNT_IN;
        w.ex = EX_CLR_ID;
      end
      5'd27: begin w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd1; w.wsel = WD_SIZE_IN; end
      5'd28: begin w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd2; w.wsel = WD_ZERO; end
      5'd29: begin w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd3; w.wsel = WD_INIT_CHK; end
      5'd30: begin
        w.wr = 1'b1; w.asel = AS_HDR; w.hofs = 3'd4; w.wsel = WD_ZERO;
        w.done = 1'b1; w.st = ST_OK;
      end
      default: begin w.done = 1'b1; w.st = ST_HDR_BAD; end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/ewl_if.sv @@
// Handshake channels of the wear-levelling block: items, results and configuration.
interface ewl_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] block_count;
  logic [7:0] user_size;
  logic [7:0] offset;
  logic [7:0] data_byte;

  modport source (output valid, op, block_count, user_size, offset, data_byte,
                  input ready);
  modport sink (input valid, op, block_count, user_size, offset, data_byte,
                output ready);
endinterface

interface ewl_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;
  logic [7:0] block_id;
  logic [7:0] wear_count;

  modport source (output valid, status, read_data, block_id, wear_count, input ready);
  modport sink (input valid, status, read_data, block_id, wear_count, output ready);
endinterface

interface ewl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/eeprom_wear_leveling_blocks_core.sv @@
// Wear-levelling store with rotating blocks: top level.
// Each item runs as a short microprogram on one single-port 256-byte store, at most
// one store access per cycle; the program is shortest for init, then longer in turn
// for header invalid, write byte, read byte and write start, and longest when a write
// start moves to the next block. A new item is taken in the cycle after the last step,
// while the previous result still waits in the output register. After reset the store
// is erased to 0xFF by a 256-byte sweep during which no item is accepted; configuration
// writes are taken at any time and must only be issued while the block is idle.
module eeprom_wear_leveling_blocks_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  ewl_item_if.sink     item_i,
  ewl_result_if.source result_o,
  ewl_cfg_if.sink      cfg_i
);
  import ewl_pkg::*;

  ucode_t            uw;
  cond_t             cond;
  logic              seq_busy, fire, accept, clr_busy;
  logic              mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wr_data, mem_rd_data;

  assign item_i.ready = !seq_busy && !clr_busy;
  assign accept       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  ewl_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (mem_wr_en),
    .rd_en_i    (mem_rd_en),
    .addr_i     (mem_addr),
    .wr_data_i  (mem_wr_data),
    .rd_data_o  (mem_rd_data),
    .clr_busy_o (clr_busy)
  );

  ewl_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .cond_i  (cond),
    .uw_o    (uw),
    .busy_o  (seq_busy),
    .fire_o  (fire)
  );

  ewl_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (item_i.op),
    .block_count_i (item_i.block_count),
    .user_size_i   (item_i.user_size),
    .offset_i      (item_i.offset),
    .data_byte_i   (item_i.data_byte),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .uw_i          (uw),
    .fire_i        (fire),
    .out_ready_i   (result_o.ready),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_rd_en_o   (mem_rd_en),
    .mem_addr_o    (mem_addr),
    .mem_wr_data_o (mem_wr_data),
    .cond_o        (cond),
    .out_valid_o   (result_o.valid),
    .status_o      (result_o.status),
    .read_data_o   (result_o.read_data),
    .block_id_o    (result_o.block_id),
    .wear_count_o  (result_o.wear_count)
  );

  a_no_item_while_erasing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !accept
  ) else $error("item accepted during erase sweep");

  a_item_starts_program: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> seq_busy
  ) else $error("accepted item did not start the sequencer");

  a_hdr_bad_zero_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status == ST_HDR_BAD) |->
      (result_o.read_data == 8'd0) && (result_o.block_id == 8'd0) &&
      (result_o.wear_count == 8'd0)
  ) else $error("header-invalid result carries data");

  a_off_bad_no_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status == ST_OFF_BAD) |-> (result_o.read_data == 8'd0)
  ) else $error("offset-invalid result carries read data");

  a_no_write_while_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !seq_busy |-> !mem_wr_en
  ) else $error("store written while sequencer idle");

endmodule

@@ hw/rtl/ewl_store.sv @@
// 256-byte store with registered read and an erase sweep after reset.
module ewl_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic                      rd_en_i,
  input  logic [ewl_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                wr_data_i,
  output logic [7:0]                rd_data_o,
  output logic                      clr_busy_o
);
  import ewl_pkg::*;

  logic [7:0]        mem [STORE_BYTES];
  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [7:0]        rd_data_q;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= ERASED;
    end else if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ hw/rtl/ewl_sequencer.sv @@
// Step counter and microcode fetch with conditional jumps.
module ewl_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ewl_pkg::cond_t  cond_i,
  output ewl_pkg::ucode_t uw_o,
  output logic            busy_o,
  output logic            fire_o
);
  import ewl_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;
  logic              take;

  assign uw = ucode_rom(step_q);

  always_comb begin
    unique case (uw.jc)
      JC_NONE:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_OP_INIT:  take = cond_i.op_init;
      JC_OP_START: take = cond_i.op_start;
      JC_OP_WRITE: take = cond_i.op_write;
      JC_HDR_BAD:  take = cond_i.hdr_bad;
      JC_OFF_BAD:  take = cond_i.off_bad;
      JC_REP_FULL: take = cond_i.rep_full;
      default:     take = 1'b0;
    endcase
  end

  // a finishing step waits here until the result register is free
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (uw.done) begin
        if (cond_i.out_free) begin
          busy_d = 1'b0;
          step_d = '0;
        end
      end else if (take) begin
        step_d = uw.jtgt;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign uw_o   = busy_q ? uw : '0;
  assign busy_o = busy_q;
  assign fire_o = busy_q && uw.done && cond_i.out_free;

endmodule

@@ hw/rtl/ewl_datapath.sv @@
// Header, block and result registers, address and write-data selection.
module ewl_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 op_i,
  input  logic [7:0]                 block_count_i,
  input  logic [7:0]                 user_size_i,
  input  logic [7:0]                 offset_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_data_i,
  input  ewl_pkg::ucode_t            uw_i,
  input  logic                       fire_i,
  input  logic                       out_ready_i,
  input  logic [7:0]                 mem_rd_data_i,
  output logic                       mem_wr_en_o,
  output logic                       mem_rd_en_o,
  output logic [ewl_pkg::ADDR_W-1:0] mem_addr_o,
  output logic [7:0]                 mem_wr_data_o,
  output ewl_pkg::cond_t             cond_o,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [7:0]                 read_data_o,
  output logic [7:0]                 block_id_o,
  output logic [7:0]                 wear_count_o
);
  import ewl_pkg::*;

  logic [7:0] base_q;
  op_e        op_q;
  logic [7:0] cnt_in_q, usz_q, off_q, dat_q;
  logic [7:0] cnt_q, sz_q, id_q, chk_q, rep_q, wear_q, rdata_q, blk_q;
  logic       out_valid_q;
  status_e    res_status_q;
  logic [7:0] res_rdata_q, res_bid_q, res_wear_q;

  logic [15:0] prod;
  logic [7:0]  blk_d;
  logic [8:0]  id_inc;
  logic [7:0]  next_id;
  logic [7:0]  size_in;
  logic [9:0]  hdr_sum;
  logic        hdr_ok;

  assign prod    = id_q * sz_q;
  assign blk_d   = base_q + HDR_LEN + prod[7:0];
  assign id_inc  = {1'b0, id_q} + 9'd1;
  assign next_id = (id_inc >= {1'b0, cnt_q}) ? 8'd0 : id_inc[7:0];
  assign size_in = usz_q + 8'd1;

  // checksum compare is on the unwrapped sum
  assign hdr_sum = {2'b00, cnt_q} + {2'b00, sz_q} + {2'b00, id_q};
  assign hdr_ok  = (hdr_sum == {2'b00, chk_q}) && (id_q < cnt_q) && (sz_q >= MIN_SIZE);

  always_comb begin
    unique case (uw_i.asel)
      AS_HDR:  mem_addr_o = base_q + {5'b00000, uw_i.hofs};
      AS_BLK:  mem_addr_o = blk_q;
      AS_USER: mem_addr_o = blk_q + 8'd1 + off_q;
      default: mem_addr_o = blk_q;
    endcase
  end

  always_comb begin
    unique case (uw_i.wsel)
      WD_ZERO:     mem_wr_data_o = 8'd0;
      WD_CNT_IN:   mem_wr_data_o = cnt_in_q;
      WD_SIZE_IN:  mem_wr_data_o = size_in;
      WD_INIT_CHK: mem_wr_data_o = cnt_in_q + size_in;
      WD_REP_INC:  mem_wr_data_o = rep_q + 8'd1;
      WD_ID:       mem_wr_data_o = id_q;
      WD_NEW_CHK:  mem_wr_data_o = cnt_q + sz_q + id_q;
      WD_DATA:     mem_wr_data_o = dat_q;
      default:     mem_wr_data_o = 8'd0;
    endcase
  end

  assign mem_wr_en_o = uw_i.wr;
  assign mem_rd_en_o = uw_i.rd;

  assign cond_o.op_init  = (op_q == OP_INIT);
  assign cond_o.op_start = (op_q == OP_START);
  assign cond_o.op_write = (op_q == OP_WRITE);
  assign cond_o.hdr_bad  = !hdr_ok;
  assign cond_o.off_bad  = {1'b0, off_q} >= ({1'b0, sz_q} - 9'd1);
  assign cond_o.rep_full = (rep_q == ERASED);
  assign cond_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (fire_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q     <= op_e'(op_i);
      cnt_in_q <= block_count_i;
      usz_q    <= user_size_i;
      off_q    <= offset_i;
      dat_q    <= data_byte_i;
      wear_q   <= 8'd0;
      rdata_q  <= 8'd0;
    end else begin
      case (uw_i.ld)
        LD_CNT:   cnt_q   <= mem_rd_data_i;
        LD_SZ:    sz_q    <= mem_rd_data_i;
        LD_ID:    id_q    <= mem_rd_data_i;
        LD_CHK:   chk_q   <= mem_rd_data_i;
        LD_REP:   rep_q   <= mem_rd_data_i;
        LD_WEAR:  wear_q  <= mem_rd_data_i;
        LD_RDATA: rdata_q <= mem_rd_data_i;
        default: ;
      endcase
      case (uw_i.ex)
        EX_BLK:     blk_q <= blk_d;
        EX_NEXT_ID: id_q  <= next_id;
        EX_CLR_ID:  id_q  <= 8'd0;
        default: ;
      endcase
    end
    // a finishing step that also loads takes the byte straight from the store
    if (fire_i) begin
      res_status_q <= uw_i.st;
      res_rdata_q  <= (uw_i.ld == LD_RDATA) ? mem_rd_data_i : rdata_q;
      res_bid_q    <= (uw_i.st == ST_HDR_BAD) ? 8'd0 : id_q;
      res_wear_q   <= (uw_i.st == ST_HDR_BAD) ? 8'd0 :
                      ((uw_i.ld == LD_WEAR) ? mem_rd_data_i : wear_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_status_q;
  assign read_data_o  = res_rdata_q;
  assign block_id_o   = res_bid_q;
  assign wear_count_o = res_wear_q;

endmodule
